/* src/tft_pkg.sv */
// Shared types and constants for the table formula tokenizer.
// Depends on nothing; every other file refers to it by scoped names.
package tft_pkg;

	// Scan mode of the tokenizer.
	typedef enum logic [1:0] {
		MODE_IDLE   = 2'd0,
		MODE_STRING = 2'd1,
		MODE_NUMBER = 2'd2,
		MODE_COORDS = 2'd3
	} scan_mode_t;

	// Event kinds of a result.
	localparam logic [2:0] EV_CELL       = 3'd0;
	localparam logic [2:0] EV_ROW        = 3'd1;
	localparam logic [2:0] EV_CHAR       = 3'd2;
	localparam logic [2:0] EV_END        = 3'd3;
	localparam logic [2:0] EV_SYMBOL     = 3'd4;
	localparam logic [2:0] EV_STREAM_END = 3'd5;

	// Token kinds reported with a token end.
	localparam logic [2:0] TK_STRING       = 3'd0;
	localparam logic [2:0] TK_NUMBER       = 3'd1;
	localparam logic [2:0] TK_COORDS       = 3'd2;
	localparam logic [2:0] TK_NUM_ERROR    = 3'd3;
	localparam logic [2:0] TK_UNTERMINATED = 3'd4;

	// Characters with a meaning of their own.
	localparam logic [7:0] CH_BAR     = 8'h7C;
	localparam logic [7:0] CH_NEWLINE = 8'h0A;
	localparam logic [7:0] CH_QUOTE   = 8'h22;
	localparam logic [7:0] CH_AT      = 8'h40;
	localparam logic [7:0] CH_MINUS   = 8'h2D;
	localparam logic [7:0] CH_DOT     = 8'h2E;

	// Dot count at which a number turns into an error.
	localparam logic [1:0] DOT_LIMIT = 2'd2;

	// Result queue geometry.
	localparam int unsigned QUEUE_DEPTH = 4;
	localparam int unsigned QUEUE_AW    = 2;
	localparam int unsigned QUEUE_CW    = 3;

	// Input transaction.
	typedef struct packed {
		logic [7:0] text_byte;
		logic       flush;
	} in_item_t;

	// Output transaction.
	typedef struct packed {
		logic [2:0] event_kind;
		logic [7:0] out_char;
		logic [2:0] token_kind;
		logic       last;
	} out_item_t;

	// Tokenizer state.
	typedef struct packed {
		scan_mode_t scan_mode;
		logic [1:0] dot_count;
		logic       minus_pending;
		logic       str_got;
	} tok_state_t;

	// Up to two results produced by one input item.
	typedef struct packed {
		logic [1:0] count;
		out_item_t  res0;
		out_item_t  res1;
	} step_res_t;

endpackage

/* src/table_formula_tokenizer.sv */
// A streaming tokenizer for a table language: one text byte per input transaction, and
// zero, one or two result transactions per byte (cell and row marks, token characters,
// token ends with their kind, symbols, end of stream). An input transaction is taken in
// every cycle in which the four-entry result queue holds two results or fewer; results
// leave at one per cycle while out_ready is high, the first appearing the cycle after
// its byte is accepted into an empty queue. With the combinational step logic, the rate
// is one byte per cycle while out_ready is high; two-result bytes are output-limited.
// Depends on tft_pkg, tft_step and tft_queue.
module table_formula_tokenizer (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  tft_pkg::in_item_t  in_data,
	output logic               out_valid,
	input  logic               out_ready,
	output tft_pkg::out_item_t out_data
);

	tft_pkg::tok_state_t state_q;
	tft_pkg::tok_state_t state_next;
	tft_pkg::step_res_t  step_res;
	tft_pkg::step_res_t  wr;
	logic                room;
	logic                in_fire;

	assign in_ready = room;
	assign in_fire  = in_valid && in_ready;

	// Per-byte decode.
	tft_step u_step (
		.item       (in_data),
		.state      (state_q),
		.state_next (state_next),
		.results    (step_res)
	);

	// Only accepted transactions write results.
	always_comb begin
		wr = step_res;
		if (!in_fire)
			wr.count = 2'd0;
	end

	// Tokenizer state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.scan_mode     <= tft_pkg::MODE_IDLE;
			state_q.dot_count     <= 2'd0;
			state_q.minus_pending <= 1'b0;
			state_q.str_got       <= 1'b0;
		end else if (in_fire) begin
			state_q <= state_next;
		end
	end

	// Result queue; its oldest entry drives the output.
	tft_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr        (wr),
		.room      (room),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

/* src/tft_step.sv */
// Combinational step of the tokenizer: next state and results for one byte.
// Depends on tft_pkg.
module tft_step (
	input  tft_pkg::in_item_t   item,
	input  tft_pkg::tok_state_t state,
	output tft_pkg::tok_state_t state_next,
	output tft_pkg::step_res_t  results
);

	typedef struct packed {
		logic                emit;
		logic [2:0]          event_kind;
		logic [7:0]          ch;
		tft_pkg::scan_mode_t mode;
		logic                set_minus;
	} idle_res_t;

	// Handling of one byte as in idle mode.
	function automatic idle_res_t idle_classify(input logic [7:0] c);
		idle_res_t r;
		r.emit       = 1'b0;
		r.event_kind = tft_pkg::EV_CELL;
		r.ch         = 8'h00;
		r.mode       = tft_pkg::MODE_IDLE;
		r.set_minus  = 1'b0;
		if (c == tft_pkg::CH_BAR) begin
			r.emit = 1'b1;
			r.event_kind = tft_pkg::EV_CELL;
		end else if (c == tft_pkg::CH_NEWLINE) begin
			r.emit = 1'b1;
			r.event_kind = tft_pkg::EV_ROW;
		end else if (c == tft_pkg::CH_QUOTE) begin
			r.mode = tft_pkg::MODE_STRING;
		end else if (is_digit(c)) begin
			r.emit = 1'b1;
			r.event_kind = tft_pkg::EV_CHAR;
			r.ch = c;
			r.mode = tft_pkg::MODE_NUMBER;
		end else if (c == tft_pkg::CH_MINUS) begin
			r.set_minus = 1'b1;
		end else if (c == tft_pkg::CH_AT) begin
			r.emit = 1'b1;
			r.event_kind = tft_pkg::EV_CHAR;
			r.ch = c;
			r.mode = tft_pkg::MODE_COORDS;
		end else if (c == 8'h2B || c == 8'h2A || c == 8'h2F || c == 8'h28 ||
				c == 8'h29 || c == 8'h3D) begin
			r.emit = 1'b1;
			r.event_kind = tft_pkg::EV_SYMBOL;
			r.ch = c;
		end
		return r;
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= 8'h30) && (c <= 8'h39);
	endfunction

	function automatic logic is_upper(input logic [7:0] c);
		return (c >= 8'h41) && (c <= 8'h5A);
	endfunction

	function automatic tft_pkg::out_item_t mk(input logic [2:0] ev, input logic [7:0] ch,
			input logic [2:0] tk);
		tft_pkg::out_item_t o;
		o.event_kind = ev;
		o.out_char   = ch;
		o.token_kind = tk;
		o.last       = 1'b0;
		return o;
	endfunction

	logic [7:0]         c;
	idle_res_t          idle_r;
	tft_pkg::out_item_t idle_item;
	logic [2:0]         num_kind;
	logic               first_v;
	logic               second_v;
	tft_pkg::out_item_t first_item;
	tft_pkg::out_item_t second_item;

	assign c         = item.text_byte;
	assign idle_r    = idle_classify(c);
	assign idle_item = mk(idle_r.event_kind, idle_r.ch, 3'd0);
	assign num_kind  = (state.dot_count >= tft_pkg::DOT_LIMIT) ?
			tft_pkg::TK_NUM_ERROR : tft_pkg::TK_NUMBER;

	// Next state.
	always_comb begin
		state_next = state;
		if (item.flush) begin
			state_next.scan_mode     = tft_pkg::MODE_IDLE;
			state_next.dot_count     = 2'd0;
			state_next.minus_pending = 1'b0;
			state_next.str_got       = 1'b0;
		end else if (state.minus_pending) begin
			if (is_digit(c)) begin
				state_next.minus_pending = 1'b0;
				state_next.scan_mode     = tft_pkg::MODE_NUMBER;
				state_next.dot_count     = 2'd0;
			end else begin
				state_next.minus_pending = idle_r.set_minus;
				state_next.scan_mode     = idle_r.mode;
				state_next.dot_count     = 2'd0;
				state_next.str_got       = 1'b0;
			end
		end else begin
			case (state.scan_mode)
				tft_pkg::MODE_STRING: begin
					if (c == tft_pkg::CH_QUOTE) begin
						state_next.scan_mode = tft_pkg::MODE_IDLE;
						state_next.str_got   = 1'b0;
					end else begin
						state_next.str_got = 1'b1;
					end
				end
				tft_pkg::MODE_NUMBER: begin
					if (is_digit(c) || c == tft_pkg::CH_DOT) begin
						if (c == tft_pkg::CH_DOT && state.dot_count < tft_pkg::DOT_LIMIT)
							state_next.dot_count = state.dot_count + 2'd1;
					end else begin
						state_next.dot_count     = 2'd0;
						state_next.scan_mode     = idle_r.mode;
						state_next.minus_pending = idle_r.set_minus;
						state_next.str_got       = 1'b0;
					end
				end
				tft_pkg::MODE_COORDS: begin
					if (!(is_digit(c) || is_upper(c))) begin
						state_next.dot_count     = 2'd0;
						state_next.scan_mode     = idle_r.mode;
						state_next.minus_pending = idle_r.set_minus;
						state_next.str_got       = 1'b0;
					end
				end
				default: begin
					state_next.dot_count     = 2'd0;
					state_next.scan_mode     = idle_r.mode;
					state_next.minus_pending = idle_r.set_minus;
					state_next.str_got       = 1'b0;
				end
			endcase
		end
	end

	// Results: an optional first one (closing or direct) and an optional second one.
	always_comb begin
		first_v     = 1'b0;
		second_v    = 1'b0;
		first_item  = mk(tft_pkg::EV_CELL, 8'h00, 3'd0);
		second_item = mk(tft_pkg::EV_CELL, 8'h00, 3'd0);
		if (item.flush) begin
			second_v    = 1'b1;
			second_item = mk(tft_pkg::EV_STREAM_END, 8'h00, 3'd0);
			if (state.minus_pending) begin
				first_v    = 1'b1;
				first_item = mk(tft_pkg::EV_SYMBOL, tft_pkg::CH_MINUS, 3'd0);
			end else begin
				case (state.scan_mode)
					tft_pkg::MODE_STRING: begin
						first_v    = 1'b1;
						first_item = mk(tft_pkg::EV_END, 8'h00, tft_pkg::TK_UNTERMINATED);
					end
					tft_pkg::MODE_NUMBER: begin
						first_v    = 1'b1;
						first_item = mk(tft_pkg::EV_END, 8'h00, num_kind);
					end
					tft_pkg::MODE_COORDS: begin
						first_v    = 1'b1;
						first_item = mk(tft_pkg::EV_END, 8'h00, tft_pkg::TK_COORDS);
					end
					default: begin
						first_v = 1'b0;
					end
				endcase
			end
		end else if (state.minus_pending) begin
			first_v = 1'b1;
			if (is_digit(c)) begin
				first_item  = mk(tft_pkg::EV_CHAR, tft_pkg::CH_MINUS, 3'd0);
				second_v    = 1'b1;
				second_item = mk(tft_pkg::EV_CHAR, c, 3'd0);
			end else begin
				first_item  = mk(tft_pkg::EV_SYMBOL, tft_pkg::CH_MINUS, 3'd0);
				second_v    = idle_r.emit;
				second_item = idle_item;
			end
		end else begin
			case (state.scan_mode)
				tft_pkg::MODE_STRING: begin
					if (c == tft_pkg::CH_QUOTE) begin
						first_v    = state.str_got;
						first_item = mk(tft_pkg::EV_END, 8'h00, tft_pkg::TK_STRING);
					end else begin
						first_v    = 1'b1;
						first_item = mk(tft_pkg::EV_CHAR, c, 3'd0);
					end
				end
				tft_pkg::MODE_NUMBER: begin
					first_v = 1'b1;
					if (is_digit(c) || c == tft_pkg::CH_DOT) begin
						first_item = mk(tft_pkg::EV_CHAR, c, 3'd0);
					end else begin
						first_item  = mk(tft_pkg::EV_END, 8'h00, num_kind);
						second_v    = idle_r.emit;
						second_item = idle_item;
					end
				end
				tft_pkg::MODE_COORDS: begin
					first_v = 1'b1;
					if (is_digit(c) || is_upper(c)) begin
						first_item = mk(tft_pkg::EV_CHAR, c, 3'd0);
					end else begin
						first_item  = mk(tft_pkg::EV_END, 8'h00, tft_pkg::TK_COORDS);
						second_v    = idle_r.emit;
						second_item = idle_item;
					end
				end
				default: begin
					second_v    = idle_r.emit;
					second_item = idle_item;
				end
			endcase
		end
	end

	// Pack the results to the front and mark the final one.
	always_comb begin
		results.res0 = second_item;
		results.res1 = second_item;
		results.count = {1'b0, second_v};
		if (first_v) begin
			results.res0  = first_item;
			results.count = second_v ? 2'd2 : 2'd1;
		end
		results.res0.last = (results.count == 2'd1);
		results.res1.last = 1'b1;
	end

endmodule

/* src/tft_queue.sv */
// Small result queue: takes up to two results a cycle, hands out one while out_ready is high.
// Depends on tft_pkg.
module tft_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  tft_pkg::step_res_t wr,
	output logic               room,
	output logic               out_valid,
	input  logic               out_ready,
	output tft_pkg::out_item_t out_data
);

	tft_pkg::out_item_t               mem_q [tft_pkg::QUEUE_DEPTH];
	logic [tft_pkg::QUEUE_AW-1:0]     head_q;
	logic [tft_pkg::QUEUE_AW-1:0]     tail_q;
	logic [tft_pkg::QUEUE_CW-1:0]     count_q;
	logic [tft_pkg::QUEUE_AW-1:0]     tail_p1;
	logic                             pop;

	assign tail_p1   = tail_q + 1'b1;
	assign out_valid = (count_q != '0);
	assign out_data  = mem_q[head_q];
	assign pop       = out_valid && out_ready;
	// Room for the largest burst one item can cause.
	assign room      = (count_q <= tft_pkg::QUEUE_CW'(tft_pkg::QUEUE_DEPTH - 2));

	// Entry storage.
	always_ff @(posedge clk) begin
		if (wr.count != 2'd0)
			mem_q[tail_q] <= wr.res0;
		if (wr.count == 2'd2)
			mem_q[tail_p1] <= wr.res1;
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else begin
			if (pop)
				head_q <= head_q + 1'b1;
			tail_q  <= tail_q + tft_pkg::QUEUE_AW'(wr.count);
			count_q <= count_q + tft_pkg::QUEUE_CW'(wr.count) - tft_pkg::QUEUE_CW'(pop);
		end
	end

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps
// Self-checking testbench for table_formula_tokenizer: drives text bytes and flushes,
// predicts the event stream in a small tracker class, and checks every result in order.
// Depends on tft_pkg and the table_formula_tokenizer RTL.
module testbench;

	localparam int BYTE_TARGET = 1800;
	localparam int CYCLE_LIMIT = 1_000_000;
	localparam int REPORT_MAX  = 10;

	// Tracks the tokenizer state and holds the events still awaited from the block.
	class token_tracker;
		tft_pkg::out_item_t  awaited_events[$];
		tft_pkg::out_item_t  step_events[$];
		tft_pkg::scan_mode_t mode;
		logic [1:0]          dots;
		logic                minus_wait;
		logic                str_nonempty;
		int                  mismatches;
		int                  bytes_seen;
		int                  flushes_seen;
		int                  events_seen;

		function new();
			clear_state();
			mismatches = 0;
			bytes_seen = 0;
			flushes_seen = 0;
			events_seen = 0;
		endfunction

		function void clear_state();
			mode = tft_pkg::MODE_IDLE;
			dots = 2'd0;
			minus_wait = 1'b0;
			str_nonempty = 1'b0;
		endfunction

		function bit is_digit(logic [7:0] c);
			return c >= "0" && c <= "9";
		endfunction

		function bit is_upper(logic [7:0] c);
			return c >= "A" && c <= "Z";
		endfunction

		function bit is_blank(logic [7:0] c);
			return c == " " || (c >= 8'd9 && c <= 8'd13 && c != tft_pkg::CH_NEWLINE);
		endfunction

		function bit is_symbol(logic [7:0] c);
			return c == "+" || c == tft_pkg::CH_MINUS || c == "*" || c == "/" ||
				c == "(" || c == ")" || c == "=";
		endfunction

		function void push(logic [2:0] kind, logic [7:0] ch, logic [2:0] tk);
			tft_pkg::out_item_t ev;
			ev.event_kind = kind;
			ev.out_char = ch;
			ev.token_kind = tk;
			ev.last = 1'b0;
			step_events.push_back(ev);
		endfunction

		function void close_number();
			push(tft_pkg::EV_END, 8'h00, (dots >= tft_pkg::DOT_LIMIT) ?
				tft_pkg::TK_NUM_ERROR : tft_pkg::TK_NUMBER);
			mode = tft_pkg::MODE_IDLE;
			dots = 2'd0;
		endfunction

		// A byte seen with no token open.
		function void idle_char(logic [7:0] c);
			if (is_blank(c))
				return;
			if (c == tft_pkg::CH_BAR) begin
				push(tft_pkg::EV_CELL, 8'h00, tft_pkg::TK_STRING);
			end else if (c == tft_pkg::CH_NEWLINE) begin
				push(tft_pkg::EV_ROW, 8'h00, tft_pkg::TK_STRING);
			end else if (c == tft_pkg::CH_QUOTE) begin
				mode = tft_pkg::MODE_STRING;
				str_nonempty = 1'b0;
			end else if (is_digit(c)) begin
				push(tft_pkg::EV_CHAR, c, tft_pkg::TK_STRING);
				mode = tft_pkg::MODE_NUMBER;
				dots = 2'd0;
			end else if (c == tft_pkg::CH_MINUS) begin
				minus_wait = 1'b1;
			end else if (c == tft_pkg::CH_AT) begin
				push(tft_pkg::EV_CHAR, c, tft_pkg::TK_STRING);
				mode = tft_pkg::MODE_COORDS;
			end else if (is_symbol(c)) begin
				push(tft_pkg::EV_SYMBOL, c, tft_pkg::TK_STRING);
			end
		endfunction

		// Works out the events caused by one accepted input transaction.
		function void note_byte(tft_pkg::in_item_t it);
			logic [7:0] c;
			c = it.text_byte;
			step_events.delete();
			bytes_seen++;
			if (it.flush) begin
				flushes_seen++;
				if (minus_wait) begin
					push(tft_pkg::EV_SYMBOL, tft_pkg::CH_MINUS, tft_pkg::TK_STRING);
				end else begin
					case (mode)
						tft_pkg::MODE_STRING:
							push(tft_pkg::EV_END, 8'h00, tft_pkg::TK_UNTERMINATED);
						tft_pkg::MODE_NUMBER: close_number();
						tft_pkg::MODE_COORDS:
							push(tft_pkg::EV_END, 8'h00, tft_pkg::TK_COORDS);
						default: ;
					endcase
				end
				push(tft_pkg::EV_STREAM_END, 8'h00, tft_pkg::TK_STRING);
				clear_state();
			end else if (minus_wait) begin
				minus_wait = 1'b0;
				if (is_digit(c)) begin
					push(tft_pkg::EV_CHAR, tft_pkg::CH_MINUS, tft_pkg::TK_STRING);
					push(tft_pkg::EV_CHAR, c, tft_pkg::TK_STRING);
					mode = tft_pkg::MODE_NUMBER;
					dots = 2'd0;
				end else begin
					push(tft_pkg::EV_SYMBOL, tft_pkg::CH_MINUS, tft_pkg::TK_STRING);
					idle_char(c);
				end
			end else if (mode == tft_pkg::MODE_STRING) begin
				if (c == tft_pkg::CH_QUOTE) begin
					if (str_nonempty)
						push(tft_pkg::EV_END, 8'h00, tft_pkg::TK_STRING);
					mode = tft_pkg::MODE_IDLE;
					str_nonempty = 1'b0;
				end else begin
					push(tft_pkg::EV_CHAR, c, tft_pkg::TK_STRING);
					str_nonempty = 1'b1;
				end
			end else if (mode == tft_pkg::MODE_NUMBER) begin
				if (is_digit(c) || c == tft_pkg::CH_DOT) begin
					if (c == tft_pkg::CH_DOT && dots < tft_pkg::DOT_LIMIT)
						dots++;
					push(tft_pkg::EV_CHAR, c, tft_pkg::TK_STRING);
				end else begin
					close_number();
					idle_char(c);
				end
			end else if (mode == tft_pkg::MODE_COORDS) begin
				if (is_digit(c) || is_upper(c)) begin
					push(tft_pkg::EV_CHAR, c, tft_pkg::TK_STRING);
				end else begin
					push(tft_pkg::EV_END, 8'h00, tft_pkg::TK_COORDS);
					mode = tft_pkg::MODE_IDLE;
					idle_char(c);
				end
			end else begin
				idle_char(c);
			end
			if (step_events.size() > 0)
				step_events[step_events.size() - 1].last = 1'b1;
			foreach (step_events[i])
				awaited_events.push_back(step_events[i]);
		endfunction

		// Compares one result transaction with the oldest awaited event.
		function void check_event(tft_pkg::out_item_t got);
			tft_pkg::out_item_t exp;
			events_seen++;
			if (awaited_events.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_MAX)
					$display("ERROR: unexpected result kind=%0d char=%02h",
						got.event_kind, got.out_char,
						" token=%0d last=%0d", got.token_kind, got.last);
				return;
			end
			exp = awaited_events.pop_front();
			if (got.event_kind !== exp.event_kind || got.out_char !== exp.out_char ||
					got.token_kind !== exp.token_kind || got.last !== exp.last) begin
				mismatches++;
				if (mismatches <= REPORT_MAX)
					$display("ERROR: result %0d expected kind=%0d char=%02h",
						events_seen, exp.event_kind, exp.out_char,
						" token=%0d last=%0d,", exp.token_kind, exp.last,
						" got kind=%0d char=%02h", got.event_kind, got.out_char,
						" token=%0d last=%0d", got.token_kind, got.last);
			end
		endfunction
	endclass

	logic               clk;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	tft_pkg::in_item_t  in_data = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	tft_pkg::out_item_t out_data;

	token_tracker tracker = new();
	int  cycles = 0;
	int  sent = 0;
	bit  sender_steady = 1'b0;
	bit  pressure_done = 1'b0;

	table_formula_tokenizer DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Watchdog on the total run length.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	// Both channels are observed at the clock edge where the transaction completes.
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready)
				tracker.note_byte(in_data);
			if (out_valid && out_ready)
				tracker.check_event(out_data);
		end
	end

	// Mostly short idle gaps, now and then a long one.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// Result side: bursts of ready broken by random stalls.
	initial begin
		int run;
		int stall;
		forever begin
			if ($urandom_range(0, 9) == 0)
				run = $urandom_range(100, 300);
			else
				run = $urandom_range(1, 20);
			out_ready <= 1'b1;
			repeat (run) @(posedge clk);
			stall = pick_gap();
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
		end
	end

	// Presents one input transaction and returns at the edge where it is taken.
	task automatic send_item(logic [7:0] c, logic fl);
		int gap;
		gap = sender_steady ? 0 : pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= '{text_byte: c, flush: fl};
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		sent++;
	endtask

	task automatic send_char(logic [7:0] c);
		send_item(c, 1'b0);
	endtask

	task automatic send_flush();
		send_item(8'($urandom_range(0, 255)), 1'b1);
	endtask

	// One random token or piece of noise; most of them well formed.
	task automatic send_token();
		string syms;
		string blanks;
		int r;
		int n;
		r = $urandom_range(0, 99);
		syms = "+-*/()=";
		blanks = " \t\013\014\r";
		if (r < 8) begin
			send_char(tft_pkg::CH_BAR);
		end else if (r < 16) begin
			send_char(tft_pkg::CH_NEWLINE);
		end else if (r < 22) begin
			send_char(blanks[$urandom_range(0, 4)]);
		end else if (r < 34) begin
			send_char(syms[$urandom_range(0, 6)]);
		end else if (r < 50) begin
			// String with arbitrary content; some are left open and flushed.
			send_char(tft_pkg::CH_QUOTE);
			n = $urandom_range(0, 6);
			repeat (n) begin
				logic [7:0] b;
				b = 8'($urandom_range(0, 255));
				if (b == tft_pkg::CH_QUOTE)
					b = 8'h23;
				send_char(b);
			end
			if ($urandom_range(0, 4) == 0)
				send_flush();
			else
				send_char(tft_pkg::CH_QUOTE);
		end else if (r < 72) begin
			// Number, sometimes negative, with zero to five dots.
			if ($urandom_range(0, 1))
				send_char(tft_pkg::CH_MINUS);
			send_char(8'("0" + $urandom_range(0, 9)));
			n = $urandom_range(0, 5);
			repeat (n) begin
				if ($urandom_range(0, 3) == 0)
					send_char(tft_pkg::CH_DOT);
				else
					send_char(8'("0" + $urandom_range(0, 9)));
			end
		end else if (r < 84) begin
			// Coordinates.
			send_char(tft_pkg::CH_AT);
			n = $urandom_range(0, 4);
			repeat (n) begin
				if ($urandom_range(0, 1))
					send_char(8'("A" + $urandom_range(0, 25)));
				else
					send_char(8'("0" + $urandom_range(0, 9)));
			end
		end else if (r < 90) begin
			// A minus that turns out to be a symbol.
			send_char(tft_pkg::CH_MINUS);
			if ($urandom_range(0, 3) == 0)
				send_flush();
			else
				send_char(syms[$urandom_range(0, 6)]);
		end else if (r < 96) begin
			send_char(8'($urandom_range(0, 255)));
		end else begin
			send_flush();
		end
	endtask

	initial begin
		string directed;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part: marks, skipped blanks, strings empty and not, a negative number
		// that saturates its dot count, coordinates ended by a symbol, a minus that is
		// not followed by a digit, unknown bytes at both extremes, and a flush in a string.
		directed = "|\n \013+\"a\"\"\"-5...@Z0=-(";
		for (int i = 0; i < directed.len(); i++)
			send_char(directed[i]);
		send_char(8'hFF);
		send_char(8'h00);
		send_char(tft_pkg::CH_QUOTE);
		send_flush();

		// Random part, with phases where the sender never idles.
		while (sent < BYTE_TARGET) begin
			if ($urandom_range(0, 29) == 0)
				sender_steady = !sender_steady;
			if (!pressure_done && sent > BYTE_TARGET / 2) begin
				// Hold off until every awaited result has arrived.
				pressure_done = 1'b1;
				in_valid <= 1'b0;
				do @(negedge clk); while (tracker.awaited_events.size() != 0);
				@(posedge clk);
			end
			send_token();
		end
		send_flush();
		in_valid <= 1'b0;

		do @(negedge clk); while (tracker.awaited_events.size() != 0);
		repeat (16) @(posedge clk);

		$display("Run covered %0d byte transactions, %0d of them flushes,",
			tracker.bytes_seen, tracker.flushes_seen,
			" and checked %0d results.", tracker.events_seen);
		$display("Mismatches: %0d, results still awaited: %0d.",
			tracker.mismatches, tracker.awaited_events.size());
		if (tracker.mismatches == 0 && tracker.awaited_events.size() == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end
endmodule
